// ===== sv/bmwd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmwd_pkg: shared types and constants of the banked memory window decoder
// field widths, register layout, action codes and parameter defaults
// ----------------------------------------------------------------------------
package bmwd_pkg;

    localparam int WINDOWS_DEF     = 4;
    localparam int STORE_DEPTH_DEF = 65536;
    localparam int ADDR_BITS_DEF   = 16;

    // field widths of one command word and one response word
    localparam int ACTION_W = 2;
    localparam int ADDRESS_W = 16;
    localparam int DATA_W = 8;
    localparam int WIN_IDX_W = 2;

    // window register layout
    localparam int CFG_W = 49;
    localparam int CFG_COUNT = 4;
    localparam int BASE_LSB = 0;
    localparam int SIZE_LSB = 16;
    localparam int OFFSET_LSB = 32;
    localparam int RAM_BIT = 48;
    localparam int FIELD_W = 16;

    // apb port: 64 bit data, registers on 8 byte steps
    localparam int PDATA_W = 64;
    localparam int PADDR_W = 5;
    localparam int PIDX_LSB = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FLAGS = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        logic                 hit;
        logic [WIN_IDX_W-1:0] window;
    } match_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage

// ===== sv/bmwd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmwd interfaces: command and response channels
// valid/ready handshake, a word moves when both are high at a clock edge
// ----------------------------------------------------------------------------
interface bmwd_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [bmwd_pkg::ACTION_W-1:0]      action;
    logic [bmwd_pkg::ADDRESS_W-1:0]     address;
    logic [bmwd_pkg::DATA_W-1:0]        write_data;
    logic                               force_req;
    logic [bmwd_pkg::WIN_IDX_W-1:0]     window_index;
    logic                               new_active;
    logic                               new_readable;

    modport source (
        output valid, action, address, write_data, force_req,
               window_index, new_active, new_readable,
        input  ready
    );
    modport sink (
        input  valid, action, address, write_data, force_req,
               window_index, new_active, new_readable,
        output ready
    );
endinterface

interface bmwd_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [bmwd_pkg::DATA_W-1:0]        read_data;
    logic                               hit;
    logic [bmwd_pkg::WIN_IDX_W-1:0]     hit_window;

    modport source (
        output valid, read_data, hit, hit_window,
        input  ready
    );
    modport sink (
        input  valid, read_data, hit, hit_window,
        output ready
    );
endinterface

// ===== sv/bmwd_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmwd_store: shared byte store
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bmwd_store #(
    parameter int STORE_DEPTH = bmwd_pkg::STORE_DEPTH_DEF,
    localparam int LOC_W = $clog2(STORE_DEPTH)
) (
    input  logic                        clk,
    input  bmwd_pkg::mem_ctl_t          ctl,
    input  logic [LOC_W-1:0]            waddr,
    input  logic [bmwd_pkg::DATA_W-1:0] wdata,
    input  logic [LOC_W-1:0]            raddr,
    output logic [bmwd_pkg::DATA_W-1:0] rdata
);

    logic [bmwd_pkg::DATA_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/bmwd_window_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmwd_window_match: window compare and priority pick
// all windows compared in parallel, lowest qualifying index wins
// ----------------------------------------------------------------------------
module bmwd_window_match #(
    parameter int WINDOWS     = bmwd_pkg::WINDOWS_DEF,
    parameter int STORE_DEPTH = bmwd_pkg::STORE_DEPTH_DEF,
    localparam int LOC_W = $clog2(STORE_DEPTH)
) (
    input  logic [WINDOWS-1:0][bmwd_pkg::CFG_W-1:0] cfg,
    input  logic [WINDOWS-1:0]                      active,
    input  logic [WINDOWS-1:0]                      readable,
    input  logic [bmwd_pkg::ADDRESS_W-1:0]          address,
    input  logic                                    is_write,
    input  logic                                    force_req,
    output bmwd_pkg::match_t                        result,
    output logic [LOC_W-1:0]                        loc
);

    // wide enough for offset plus size and for the store depth itself
    localparam int SUM_W = ($clog2(STORE_DEPTH) + 1 > 18) ? $clog2(STORE_DEPTH) + 1 : 18;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(STORE_DEPTH);

    logic [WINDOWS-1:0]            covered;
    logic [WINDOWS-1:0]            qual;
    logic [WINDOWS-1:0][LOC_W-1:0] lane_loc;

    always_comb
    begin
        logic [bmwd_pkg::FIELD_W-1:0] base;
        logic [bmwd_pkg::FIELD_W-1:0] delta;
        logic [SUM_W-1:0]             off_s;
        logic [SUM_W-1:0]             size_s;
        logic [SUM_W-1:0]             sum_s;
        for (int w = 0; w < WINDOWS; w++)
        begin
            base   = cfg[w][bmwd_pkg::BASE_LSB +: bmwd_pkg::FIELD_W];
            off_s  = SUM_W'(cfg[w][bmwd_pkg::OFFSET_LSB +: bmwd_pkg::FIELD_W]);
            size_s = SUM_W'(cfg[w][bmwd_pkg::SIZE_LSB +: bmwd_pkg::FIELD_W]) + SUM_W'(1);
            // a window running past the end of the store maps all of it
            if (off_s + size_s > DEPTH_S)
            begin
                off_s  = '0;
                size_s = DEPTH_S;
            end
            delta       = address - base;
            covered[w]  = (address >= base) && (SUM_W'(delta) < size_s);
            sum_s       = off_s + SUM_W'(delta);
            lane_loc[w] = sum_s[LOC_W-1:0];
            if (is_write)
            begin
                qual[w] = active[w] && (cfg[w][bmwd_pkg::RAM_BIT] || force_req);
            end
            else
            begin
                qual[w] = active[w] && readable[w];
            end
        end
    end

    always_comb
    begin
        result.hit    = 1'b0;
        result.window = '0;
        loc           = '0;
        for (int w = 0; w < WINDOWS; w++)
        begin
            if (!result.hit && qual[w] && covered[w])
            begin
                result.hit    = 1'b1;
                result.window = bmwd_pkg::WIN_IDX_W'(w);
                loc           = lane_loc[w];
            end
        end
    end

endmodule

// ===== sv/banked_memory_window_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_memory_window_decoder_core: bank-switched memory map decoder
// overlapping address windows onto one shared byte store, apb configured
// ----------------------------------------------------------------------------
// Each command word is captured in an input register; the window compares and
// the priority pick then run on it and land in the response register
// together with the store's registered read, so a new word is taken every
// cycle while the response side keeps up. After reset a clearing pass
// writes zero to every store byte, one byte a cycle; no command word is
// taken during it, though apb register writes are accepted as usual. Window
// registers sit at byte address 8*i on a 64 bit data bus; reads return them.
// ----------------------------------------------------------------------------
module banked_memory_window_decoder_core #(
    parameter int WINDOWS     = bmwd_pkg::WINDOWS_DEF,
    parameter int STORE_DEPTH = bmwd_pkg::STORE_DEPTH_DEF,
    parameter int ADDR_BITS   = bmwd_pkg::ADDR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bmwd_cmd_if.sink                       cmd,
    bmwd_rsp_if.source                     rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bmwd_pkg::PADDR_W-1:0]   paddr,
    input  logic [bmwd_pkg::PDATA_W-1:0]   pwdata,
    output logic [bmwd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int LOC_W = $clog2(STORE_DEPTH);
    localparam int PIDX_W = bmwd_pkg::PADDR_W - bmwd_pkg::PIDX_LSB;
    // address bits above ADDR_BITS are not decoded
    localparam logic [bmwd_pkg::ADDRESS_W-1:0] ADDR_MASK =
        (ADDR_BITS >= bmwd_pkg::ADDRESS_W) ? '1 :
        bmwd_pkg::ADDRESS_W'((32'd1 << ADDR_BITS) - 32'd1);
    localparam logic [LOC_W-1:0] LAST_LOC = LOC_W'(STORE_DEPTH - 1);

    // ---------------- configuration ----------------
    logic [WINDOWS-1:0][bmwd_pkg::CFG_W-1:0] cfg_reg;
    logic                                    cfg_wr;
    logic [PIDX_W-1:0]                       cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[bmwd_pkg::PADDR_W-1:bmwd_pkg::PIDX_LSB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            for (int w = 0; w < WINDOWS; w++)
            begin
                // only the first four windows have a register
                if (w < bmwd_pkg::CFG_COUNT && 32'(cfg_idx) == w)
                begin
                    cfg_reg[w] <= pwdata[bmwd_pkg::CFG_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int w = 0; w < WINDOWS; w++)
        begin
            if (w < bmwd_pkg::CFG_COUNT && 32'(cfg_idx) == w)
            begin
                prdata = bmwd_pkg::PDATA_W'(cfg_reg[w]);
            end
        end
    end

    // ---------------- store clearing pass ----------------
    logic             clr_busy_reg;
    logic             clr_busy_next;
    logic [LOC_W-1:0] clr_addr_reg;
    logic [LOC_W-1:0] clr_addr_next;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + LOC_W'(1);
            if (clr_addr_reg == LAST_LOC)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // ---------------- input register ----------------
    logic                                in_valid_reg;
    logic                                in_valid_next;
    bmwd_pkg::action_t                   act_reg;
    logic [bmwd_pkg::ADDRESS_W-1:0]      addr_reg;
    logic [bmwd_pkg::DATA_W-1:0]         wdata_reg;
    logic                                force_reg;
    logic [bmwd_pkg::WIN_IDX_W-1:0]      widx_reg;
    logic                                nact_reg;
    logic                                nrd_reg;
    logic                                advance;
    logic                                cmd_take;

    logic                                out_valid_reg;
    logic                                out_valid_next;

    // the word in the input register moves on when the response slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !clr_busy_reg && (!in_valid_reg || advance);
    assign cmd_take = cmd.valid && cmd.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            act_reg   <= bmwd_pkg::action_t'(cmd.action);
            addr_reg  <= cmd.address & ADDR_MASK;
            wdata_reg <= cmd.write_data;
            force_reg <= cmd.force_req;
            widx_reg  <= cmd.window_index;
            nact_reg  <= cmd.new_active;
            nrd_reg   <= cmd.new_readable;
        end
    end

    // ---------------- window flags ----------------
    logic [WINDOWS-1:0] active_reg;
    logic [WINDOWS-1:0] readable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '1;
            readable_reg <= '1;
        end
        else if (advance && act_reg == bmwd_pkg::ACT_FLAGS)
        begin
            // an index past the last window changes nothing
            for (int w = 0; w < WINDOWS; w++)
            begin
                if (32'(widx_reg) == w)
                begin
                    active_reg[w]   <= nact_reg;
                    readable_reg[w] <= nrd_reg;
                end
            end
        end
    end

    // ---------------- decode ----------------
    bmwd_pkg::match_t   match;
    logic [LOC_W-1:0]   match_loc;
    logic               is_read;
    logic               is_write;

    assign is_read  = (act_reg == bmwd_pkg::ACT_READ);
    assign is_write = (act_reg == bmwd_pkg::ACT_WRITE);

    bmwd_window_match #(
        .WINDOWS     (WINDOWS),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_match (
        .cfg       (cfg_reg),
        .active    (active_reg),
        .readable  (readable_reg),
        .address   (addr_reg),
        .is_write  (is_write),
        .force_req (force_reg),
        .result    (match),
        .loc       (match_loc)
    );

    // ---------------- store ----------------
    bmwd_pkg::mem_ctl_t          mem_ctl;
    logic [LOC_W-1:0]            mem_waddr;
    logic [bmwd_pkg::DATA_W-1:0] mem_wdata;
    logic [bmwd_pkg::DATA_W-1:0] mem_rdata;

    // clearing pass owns the write port until it finishes
    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_ctl.we = 1'b1;
            mem_waddr  = clr_addr_reg;
            mem_wdata  = '0;
        end
        else
        begin
            mem_ctl.we = advance && is_write && match.hit;
            mem_waddr  = match_loc;
            mem_wdata  = wdata_reg;
        end
        mem_ctl.re = advance && is_read && match.hit;
    end

    bmwd_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (match_loc),
        .rdata (mem_rdata)
    );

    // ---------------- response register ----------------
    logic                           hit_reg;
    logic [bmwd_pkg::WIN_IDX_W-1:0] hitw_reg;
    logic                           rd_sel_reg;
    logic                           acc_hit;

    // flag setting and the unused code answer as a miss
    assign acc_hit = (is_read || is_write) && match.hit;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg    <= acc_hit;
            hitw_reg   <= acc_hit ? match.window : '0;
            rd_sel_reg <= is_read && match.hit;
        end
    end

    // the store's read register holds while the response stalls
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = rd_sel_reg ? mem_rdata : '0;
    assign rsp.hit        = hit_reg;
    assign rsp.hit_window = hitw_reg;

    // ---------------- assertions ----------------
    a_clear_len : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_busy_reg) |-> $past(clr_addr_reg) == LAST_LOC)
        else $error("clearing pass ended early");

    a_no_stall_write : assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.we && !clr_busy_reg) |-> (!out_valid_reg || rsp.ready))
        else $error("store written by a stalled word");

    a_advance_shows : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced word lost");

    a_miss_window : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.hit) |-> (rsp.hit_window == '0 && rsp.read_data == '0))
        else $error("miss response carries data");

endmodule
